// ===== src/plhl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plhl_pkg
// Shared types and constants for the piecewise-linear height lookup unit.
// ---------------------------------------------------------------------------
package plhl_pkg;

    // Breakpoint table geometry
    localparam int POINTS   = 1024;
    localparam int ADDR_W   = $clog2(POINTS);
    localparam int COUNT_W  = $clog2(POINTS + 1);
    localparam int CFG_W    = 11;
    localparam int INDEX_W  = 10;
    localparam int COORD_W  = 32;
    localparam int ENTRY_W  = 2 * COORD_W;

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = ENTRY_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Input operation codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_LOADP,
        ST_SCAN,
        ST_MUL,
        ST_DIVS,
        ST_DIV,
        ST_PUSH
    } plhl_state_t;

    // Result source
    typedef enum logic [1:0] {
        RES_MISS,
        RES_FLAT,
        RES_INTERP
    } plhl_res_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      wr_en;
        logic      q_load;
        logic      addr_inc;
        logic      prev_load;
        logic      seg_load;
        logic      mul_load;
        logic      div_start;
        logic      div_step;
        logic      res_load;
        plhl_res_t res_sel;
        logic      out_push;
    } plhl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic n_short;
        logic seg_match;
        logic seg_last;
        logic den_zero;
        logic div_done;
        logic out_free;
    } plhl_sts_t;

endpackage
`default_nettype wire

// ===== src/piecewise_linear_height_lookup_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// piecewise_linear_height_lookup_unit
// Breakpoint table with first-match segment search and linear interpolation.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): func selects a write beat, which
//   stores (point_x, point_y) at point_index and yields no result, or a
//   query beat, which looks up the height at query_x.
//   Output channel (out_valid / out_stall): one beat per query carrying
//   height_value and hit; a miss gives zero with hit clear.
//   cfg_wr_en / cfg_wr_data set point_count; write it only while idle.
// Timing:
//   A write beat is stored while idle. A query walks the segments one per
//   cycle through the single read port of the breakpoint memory, then
//   runs one multiply, one divider load and a 64-step restoring divide;
//   the result is pushed into the output register once that is free,
//   and only then is the next beat taken. A miss or a zero-width segment
//   skips the divide.
// Reset clears point_count and the control state; table contents are
//   undefined until written. While the receiver stalls, the finished
//   result holds in the output register and the block keeps taking beats
//   until a second query result is ready.
// ---------------------------------------------------------------------------
module piecewise_linear_height_lookup_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         func,
    input  wire logic [plhl_pkg::INDEX_W-1:0] point_index,
    input  wire logic signed [31:0]           point_x,
    input  wire logic signed [31:0]           point_y,
    input  wire logic signed [31:0]           query_x,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [31:0]                height_value,
    output logic                              hit,
    input  wire logic                         cfg_wr_en,
    input  wire logic [plhl_pkg::CFG_W-1:0]   cfg_wr_data
);
    import plhl_pkg::*;

    plhl_cmd_t cmd;
    plhl_sts_t sts;

    // Sequencer
    plhl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, arithmetic and output register
    plhl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .point_index  (point_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .query_x      (query_x),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .height_value (height_value),
        .hit          (hit)
    );

endmodule
`default_nettype wire

// ===== src/plhl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plhl_ctrl
// Sequencer: accepts beats, steps the segment scan, the multiply and the
// divider, then hands the result to the output register.
// ---------------------------------------------------------------------------
module plhl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                func,
    output logic                     in_stall,
    input  wire plhl_pkg::plhl_sts_t sts,
    output plhl_pkg::plhl_cmd_t      cmd
);
    import plhl_pkg::*;

    plhl_state_t state_reg;
    plhl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_MISS;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.q_load = 1'b1;
                        state_next = ST_PRIME;
                    end
                end
            end
            ST_PRIME:
            begin
                // Drop straight to a miss when fewer than two points
                if (sts.n_short)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_MISS;
                    state_next   = ST_PUSH;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = ST_LOADP;
                end
            end
            ST_LOADP:
            begin
                cmd.prev_load = 1'b1;
                cmd.addr_inc  = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.seg_match)
                begin
                    cmd.seg_load = 1'b1;
                    state_next   = ST_MUL;
                end
                else if (sts.seg_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_MISS;
                    state_next   = ST_PUSH;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.addr_inc  = 1'b1;
                end
            end
            ST_MUL:
            begin
                // A zero-width segment takes its left height
                if (sts.den_zero)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FLAT;
                    state_next   = ST_PUSH;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    state_next   = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Push only into a free output register
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_push |-> sts.out_free)
        else $error("result pushed into occupied output register");

    // A query beat is always followed by the scan setup
    a_query_prime: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_load |=> state_reg == ST_PRIME)
        else $error("query beat not followed by scan setup");

    // Division always follows a nonzero-width match
    a_div_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_load |=> cmd.div_start)
        else $error("divider not started after multiply");

endmodule
`default_nettype wire

// ===== src/plhl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// plhl_dp
// Datapath: breakpoint memory, segment compare, multiplier, restoring
// divider, result and output registers.
// ---------------------------------------------------------------------------
module plhl_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire plhl_pkg::plhl_cmd_t          cmd,
    output plhl_pkg::plhl_sts_t               sts,
    input  wire logic                         cfg_wr_en,
    input  wire logic [plhl_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire logic [plhl_pkg::INDEX_W-1:0] point_index,
    input  wire logic signed [31:0]           point_x,
    input  wire logic signed [31:0]           point_y,
    input  wire logic signed [31:0]           query_x,
    input  wire logic                         out_stall,
    output logic                              out_valid,
    output logic signed [31:0]                height_value,
    output logic                              hit
);
    import plhl_pkg::*;

    logic [CFG_W-1:0]          point_count_reg;
    logic [ENTRY_W-1:0]        mem [POINTS];
    logic [ENTRY_W-1:0]        rdata_reg;
    logic [ENTRY_W-1:0]        prev_reg;
    logic [COUNT_W-1:0]        addr_reg;
    logic [COUNT_W-1:0]        n_reg;
    logic signed [COORD_W-1:0] qx_reg;
    logic [COORD_W-1:0]        den_reg;
    logic [COORD_W-1:0]        num_reg;
    logic [COORD_W-1:0]        mag_reg;
    logic                      neg_reg;
    logic [COORD_W-1:0]        y1_reg;
    logic [ENTRY_W-1:0]        prod_reg;
    logic [COORD_W-1:0]        rem_reg;
    logic [ENTRY_W-1:0]        quo_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [COORD_W-1:0]        res_val_reg;
    logic                      res_hit_reg;
    logic                      out_valid_reg;
    logic [COORD_W-1:0]        out_val_reg;
    logic                      out_hit_reg;

    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W:0]   den_w;
    logic signed [COORD_W:0]   num_w;
    logic signed [COORD_W:0]   dy_w;
    logic [COORD_W:0]          mag_w;
    logic [ENTRY_W-1:0]        mul_full;
    logic [COORD_W:0]          rem_sh;
    logic [COORD_W:0]          rem_diff;
    logic                      rem_ge;
    logic [COORD_W-1:0]        q_low;
    logic [COORD_W-1:0]        interp;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            point_count_reg <= cfg_wr_data;
        end
    end

    // Breakpoint memory: x in the upper half, y in the lower half
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[point_index[ADDR_W-1:0]] <= {point_x, point_y};
        end
        rdata_reg <= mem[addr_reg[ADDR_W-1:0]];
    end

    // Query capture and scan address
    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            qx_reg   <= query_x;
            addr_reg <= '0;
            if (point_count_reg > CFG_W'(POINTS))
            begin
                n_reg <= COUNT_W'(POINTS);
            end
            else
            begin
                n_reg <= point_count_reg[COUNT_W-1:0];
            end
        end
        else if (cmd.addr_inc)
        begin
            addr_reg <= addr_reg + COUNT_W'(1);
        end
        if (cmd.prev_load)
        begin
            prev_reg <= rdata_reg;
        end
    end

    // Segment compare: left end in prev_reg, right end in rdata_reg
    assign x1 = $signed(prev_reg[ENTRY_W-1:COORD_W]);
    assign y1 = $signed(prev_reg[COORD_W-1:0]);
    assign x2 = $signed(rdata_reg[ENTRY_W-1:COORD_W]);
    assign y2 = $signed(rdata_reg[COORD_W-1:0]);

    assign den_w = {x2[COORD_W-1], x2} - {x1[COORD_W-1], x1};
    assign num_w = {qx_reg[COORD_W-1], qx_reg} - {x1[COORD_W-1], x1};
    assign dy_w  = {y2[COORD_W-1], y2} - {y1[COORD_W-1], y1};
    assign mag_w = dy_w[COORD_W] ? (COORD_W+1)'(-dy_w) : dy_w;

    // Latch the matched segment
    always_ff @(posedge clk)
    begin
        if (cmd.seg_load)
        begin
            den_reg <= den_w[COORD_W-1:0];
            num_reg <= num_w[COORD_W-1:0];
            mag_reg <= mag_w[COORD_W-1:0];
            neg_reg <= dy_w[COORD_W];
            y1_reg  <= y1;
        end
    end

    // Product of height span and offset
    assign mul_full = mag_reg * num_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg <= mul_full;
        end
    end

    // Restoring divider, one quotient bit a step
    assign rem_sh   = {rem_reg, quo_reg[ENTRY_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            quo_reg     <= prod_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_ge ? rem_diff[COORD_W-1:0] : rem_sh[COORD_W-1:0];
            quo_reg     <= {quo_reg[ENTRY_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign q_low  = quo_reg[COORD_W-1:0];
    assign interp = neg_reg ? (y1_reg - q_low) : (y1_reg + q_low);

    // Result register; the interpolated value is taken on the last divider step
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                RES_MISS:
                begin
                    res_val_reg <= '0;
                    res_hit_reg <= 1'b0;
                end
                RES_FLAT:
                begin
                    res_val_reg <= y1_reg;
                    res_hit_reg <= 1'b1;
                end
                default:
                begin
                    res_val_reg <= interp;
                    res_hit_reg <= 1'b1;
                end
            endcase
        end
        else if (cmd.div_step && sts.div_done)
        begin
            res_val_reg <= neg_reg ? (y1_reg - {quo_reg[COORD_W-2:0], rem_ge})
                                   : (y1_reg + {quo_reg[COORD_W-2:0], rem_ge});
            res_hit_reg <= 1'b1;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_push)
        begin
            out_val_reg <= res_val_reg;
            out_hit_reg <= res_hit_reg;
        end
    end

    // Status back to the controller
    always_comb
    begin
        sts.n_short   = n_reg < COUNT_W'(2);
        sts.seg_match = (x1 <= qx_reg) && (x2 >= qx_reg);
        sts.seg_last  = addr_reg == n_reg;
        sts.den_zero  = den_reg == '0;
        sts.div_done  = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign height_value = out_val_reg;
    assign hit          = out_hit_reg;

    // Scan address never steps past the number of points in use
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.addr_inc |-> addr_reg < n_reg)
        else $error("scan address beyond point count");

    // A miss always carries a zero height
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && cmd.res_sel == RES_MISS) |=> (!res_hit_reg && res_val_reg == '0))
        else $error("miss result with nonzero height");

    // A matched segment never has its left end right of the query
    a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seg_load |-> (!num_w[COORD_W] && !den_w[COORD_W] && num_w <= den_w))
        else $error("matched segment does not bracket query");

endmodule
`default_nettype wire
